[rtl/scvf_pkg.sv]
package scvf_pkg;

	localparam int SUBDIV_DEF = 8;

	localparam int COORD_W = 32;
	localparam int SIZE_W  = 31;
	localparam int RAD_W   = 31;
	localparam int COUNT_W = 10;
	localparam int CLASS_W = 2;

	// scaled offsets stay below 2^39 in magnitude for every subdivision in range
	localparam int VAL_W = 40;
	localparam int MAG_W = VAL_W - 1;
	localparam int SQ_W  = 2 * MAG_W;
	localparam int SUM_W = SQ_W + 2;

	localparam logic [CLASS_W-1:0] CLASS_INSIDE  = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_OUTSIDE = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_SAMPLED = 2'd2;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	typedef enum logic [1:0] {
		KIND_RADIUS,
		KIND_CORNER,
		KIND_SAMPLE
	} kind_t;

	typedef struct packed {
		logic  valid;
		logic  first;
		logic  last;
		kind_t kind;
	} tag_t;

	typedef struct packed {
		logic busy;
		logic all_in;
		logic all_out;
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_INIT,
		ST_CORNER,
		ST_CDRAIN,
		ST_SAMPLE,
		ST_SDRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] cz;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] cx;
		logic [SIZE_W-1:0]         sz;
		logic [SIZE_W-1:0]         sy;
		logic [SIZE_W-1:0]         sx;
		logic signed [COORD_W-1:0] z_low;
		logic signed [COORD_W-1:0] y_low;
		logic signed [COORD_W-1:0] x_low;
	} cell_t;

endpackage

[rtl/sphere_cell_volume_fraction.sv]
// sphere / box cell volume fraction by sub-cell sampling
//
// input stream (s_axis_*): one transaction per cell, carrying the low corner and
// sphere centre (Q16.16) and the three extents (unsigned Q15.16). output stream
// (m_axis_*): one transaction per cell with the count of sample points outside
// the sphere out of SUBDIV cubed, and the cell class in tuser.
// cfg_we / cfg_wdata write the sphere radius (unsigned Q15.16); write it only
// while the block is idle.
//
// one squaring unit (three pipeline stages, one axis per cycle) and one
// accumulate / compare stage are shared by the radius, the 8 corners and the
// samples. the three axes of each point go through the squarer in turn.
// s_axis_tready is high only while no cell is in work, so a new cell is taken
// only after the previous one has finished.
//
// reset clears the sequencer and the output valid flag and sets the radius to 1.0.
// a finished result waits in the output register while m_axis_tready is low;
// the next cell may be accepted meanwhile, and its result is held back until
// the register is free.
module sphere_cell_volume_fraction #(
	parameter int SUBDIV = scvf_pkg::SUBDIV_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// cell_x_low, cell_y_low, cell_z_low, cell_size_x, cell_size_y, cell_size_z,
	// centre_x, centre_y, centre_z
	input  logic [287:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// outside_count
	output logic [15:0]  m_axis_tdata,
	// cell_class
	output logic [1:0]   m_axis_tuser,
	input  logic         cfg_we,
	input  logic [30:0]  cfg_wdata
);
	import scvf_pkg::*;

	localparam int NW = $clog2(SUBDIV**3 + 1);
	localparam int EW = (NW > COUNT_W) ? NW : COUNT_W;
	localparam int MAX_CNT = 2**COUNT_W - 1;
	localparam logic [COUNT_W-1:0] FULL_CNT =
		COUNT_W'((SUBDIV**3 > MAX_CNT) ? MAX_CNT : SUBDIV**3);

	logic [RAD_W-1:0]        radius_q;
	cell_t                   cell_in;
	stat_t                   stat;
	tag_t                    iss_tag, sq_tag;
	logic signed [VAL_W-1:0] iss_val;
	logic [SQ_W-1:0]         sq;
	logic                    sq_busy, clr, fin, out_free;
	logic [CLASS_W-1:0]      cls;
	logic [NW-1:0]           count;
	logic [EW-1:0]           count_e;
	logic [COUNT_W-1:0]      count_sat;
	logic                    out_valid_q;
	logic [COUNT_W-1:0]      out_count_q;
	logic [CLASS_W-1:0]      out_class_q;

	assign cell_in.x_low = s_axis_tdata[31:0];
	assign cell_in.y_low = s_axis_tdata[63:32];
	assign cell_in.z_low = s_axis_tdata[95:64];
	assign cell_in.sx    = s_axis_tdata[126:96];
	assign cell_in.sy    = s_axis_tdata[157:127];
	assign cell_in.sz    = s_axis_tdata[188:158];
	assign cell_in.cx    = s_axis_tdata[220:189];
	assign cell_in.cy    = s_axis_tdata[252:221];
	assign cell_in.cz    = s_axis_tdata[284:253];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RAD_W'(65536);
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	assign out_free = !out_valid_q || m_axis_tready;

	scvf_seq #(.SUBDIV(SUBDIV)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cell_in  (cell_in),
		.radius   (radius_q),
		.stat     (stat),
		.out_free (out_free),
		.clr      (clr),
		.iss_tag  (iss_tag),
		.iss_val  (iss_val),
		.fin      (fin),
		.cls      (cls)
	);

	scvf_sq u_sq (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (iss_tag),
		.val     (iss_val),
		.tag_out (sq_tag),
		.sq      (sq),
		.busy    (sq_busy)
	);

	scvf_acc #(.SUBDIV(SUBDIV)) u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (clr),
		.tag_in  (sq_tag),
		.sq      (sq),
		.sq_busy (sq_busy),
		.stat    (stat),
		.count   (count)
	);

	assign count_e   = EW'(count);
	assign count_sat = (count_e > EW'(MAX_CNT)) ? COUNT_W'(MAX_CNT) : count_e[COUNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			out_class_q <= cls;
			case (cls)
				CLASS_INSIDE: out_count_q <= '0;
				CLASS_OUTSIDE: out_count_q <= FULL_CNT;
				default: out_count_q <= count_sat;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(16 - COUNT_W){1'b0}}, out_count_q};
	assign m_axis_tuser  = out_class_q;

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !stat.busy)
		else $error("cell accepted while the distance pipeline holds work");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("ready stayed high after a cell was taken");

	a_inside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == CLASS_INSIDE |-> m_axis_tdata == 16'd0)
		else $error("inside cell with a nonzero count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[COUNT_W-1:0] <= FULL_CNT)
		else $error("count above the full cell value");

endmodule

[rtl/scvf_sq.sv]
module scvf_sq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  scvf_pkg::tag_t                      tag_in,
	input  logic signed [scvf_pkg::VAL_W-1:0]   val,
	output scvf_pkg::tag_t                      tag_out,
	output logic [scvf_pkg::SQ_W-1:0]           sq,
	output logic                                busy
);
	import scvf_pkg::*;

	localparam int LO_W = 20;
	localparam int HI_W = MAG_W - LO_W;

	tag_t tag_s1, tag_s2, tag_s3;

	logic [VAL_W-1:0]     neg;
	logic [MAG_W-1:0]     mag_s1;
	logic [2*LO_W-1:0]    pll_s2;
	logic [LO_W+HI_W-1:0] plh_s2;
	logic [2*HI_W-1:0]    phh_s2;
	logic [SQ_W-1:0]      sq_s3;

	assign neg = ~val + VAL_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	// split square: hi^2 << 2*LO_W, 2*hi*lo << LO_W, lo^2
	always_ff @(posedge clk) begin
		mag_s1 <= val[VAL_W-1] ? neg[MAG_W-1:0] : val[MAG_W-1:0];
		pll_s2 <= mag_s1[LO_W-1:0] * mag_s1[LO_W-1:0];
		plh_s2 <= mag_s1[LO_W-1:0] * mag_s1[MAG_W-1:LO_W];
		phh_s2 <= mag_s1[MAG_W-1:LO_W] * mag_s1[MAG_W-1:LO_W];
		sq_s3  <= {phh_s2, {(2*LO_W){1'b0}}} + (SQ_W'(plh_s2) << (LO_W + 1))
			+ SQ_W'(pll_s2);
	end

	assign tag_out = tag_s3;
	assign sq      = sq_s3;
	assign busy    = tag_s1.valid | tag_s2.valid | tag_s3.valid;

endmodule

[rtl/scvf_acc.sv]
module scvf_acc #(
	parameter int SUBDIV = scvf_pkg::SUBDIV_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   clr,
	input  scvf_pkg::tag_t                         tag_in,
	input  logic [scvf_pkg::SQ_W-1:0]              sq,
	input  logic                                   sq_busy,
	output scvf_pkg::stat_t                        stat,
	output logic [$clog2(SUBDIV**3 + 1)-1:0]       count
);
	import scvf_pkg::*;

	localparam int NW = $clog2(SUBDIV**3 + 1);

	tag_t             tag_s4;
	logic [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0] r2_q;
	logic             all_in_q, all_out_q;
	logic [NW-1:0]    cnt_q;
	logic             gt, lt, done;

	assign gt   = acc_q > r2_q;
	assign lt   = acc_q < r2_q;
	assign done = tag_s4.valid & tag_s4.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s4 <= '0;
		end else begin
			tag_s4 <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_in.valid) begin
			if (tag_in.first) begin
				acc_q <= SUM_W'(sq);
			end else begin
				acc_q <= acc_q + SUM_W'(sq);
			end
		end
		if (done && tag_s4.kind == KIND_RADIUS) begin
			r2_q <= acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			all_in_q  <= 1'b1;
			all_out_q <= 1'b1;
			cnt_q     <= '0;
		end else if (clr) begin
			all_in_q  <= 1'b1;
			all_out_q <= 1'b1;
			cnt_q     <= '0;
		end else if (done) begin
			case (tag_s4.kind)
				KIND_CORNER: begin
					if (!lt) begin
						all_in_q <= 1'b0;
					end
					if (!gt) begin
						all_out_q <= 1'b0;
					end
				end
				KIND_SAMPLE: begin
					if (gt) begin
						cnt_q <= cnt_q + NW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	assign stat.busy    = sq_busy | tag_s4.valid;
	assign stat.all_in  = all_in_q;
	assign stat.all_out = all_out_q;
	assign count        = cnt_q;

endmodule

[rtl/scvf_seq.sv]
module scvf_seq #(
	parameter int SUBDIV = scvf_pkg::SUBDIV_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  scvf_pkg::cell_t                     cell_in,
	input  logic [scvf_pkg::RAD_W-1:0]          radius,
	input  scvf_pkg::stat_t                     stat,
	input  logic                                out_free,
	output logic                                clr,
	output scvf_pkg::tag_t                      iss_tag,
	output logic signed [scvf_pkg::VAL_W-1:0]   iss_val,
	output logic                                fin,
	output logic [scvf_pkg::CLASS_W-1:0]        cls
);
	import scvf_pkg::*;

	localparam int K  = 2 * SUBDIV;
	localparam int CW = $clog2(SUBDIV + 1);
	localparam logic [CW-1:0] LAST = CW'(SUBDIV - 1);

	state_t state_q, state_d;
	cell_t  cell_q;

	logic signed [COORD_W-1:0] low_in [3];
	logic signed [COORD_W-1:0] cen_in [3];
	logic [SIZE_W-1:0]         size_in [3];
	logic signed [COORD_W:0]   diff [3];

	logic signed [VAL_W-1:0] lo_q [3];
	logic signed [VAL_W-1:0] hi_q [3];
	logic signed [VAL_W-1:0] ks_q [3];
	logic signed [VAL_W-1:0] st_q [3];
	logic signed [VAL_W-1:0] cur_q [3];

	logic [2:0]              ci_q;
	logic [1:0]              ax_q;
	logic [CW-1:0]           a_q, b_q, c_q;
	logic [CLASS_W-1:0]      cls_q;
	logic signed [VAL_W-1:0] rs;
	logic                    corner_end, sample_end;

	assign low_in[0]  = cell_q.x_low;
	assign low_in[1]  = cell_q.y_low;
	assign low_in[2]  = cell_q.z_low;
	assign cen_in[0]  = cell_q.cx;
	assign cen_in[1]  = cell_q.cy;
	assign cen_in[2]  = cell_q.cz;
	assign size_in[0] = cell_q.sx;
	assign size_in[1] = cell_q.sy;
	assign size_in[2] = cell_q.sz;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = {low_in[i][COORD_W-1], low_in[i]} - {cen_in[i][COORD_W-1], cen_in[i]};
		end
	end

	assign rs = VAL_W'(radius) * VAL_W'(K);

	assign corner_end = (ax_q == AX_Z) && (ci_q == 3'd7);
	assign sample_end = (ax_q == AX_Z) && (a_q == LAST) && (b_q == LAST) && (c_q == LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: state_d = ST_INIT;
			ST_INIT: state_d = ST_CORNER;
			ST_CORNER: begin
				if (corner_end) begin
					state_d = ST_CDRAIN;
				end
			end
			ST_CDRAIN: begin
				if (!stat.busy) begin
					state_d = (stat.all_in || stat.all_out) ? ST_FINISH : ST_SAMPLE;
				end
			end
			ST_SAMPLE: begin
				if (sample_end) begin
					state_d = ST_SDRAIN;
				end
			end
			ST_SDRAIN: begin
				if (!stat.busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		clr           = 1'b0;
		fin           = 1'b0;
		iss_tag       = '0;
		iss_tag.kind  = KIND_CORNER;
		iss_val       = '0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SETUP: begin
				clr           = 1'b1;
				iss_tag.valid = 1'b1;
				iss_tag.first = 1'b1;
				iss_tag.last  = 1'b1;
				iss_tag.kind  = KIND_RADIUS;
				iss_val       = rs;
			end
			ST_CORNER: begin
				iss_tag.valid = 1'b1;
				iss_tag.first = (ax_q == AX_X);
				iss_tag.last  = (ax_q == AX_Z);
				iss_tag.kind  = KIND_CORNER;
				case (ax_q)
					AX_X: iss_val = ci_q[2] ? hi_q[0] : lo_q[0];
					AX_Y: iss_val = ci_q[1] ? hi_q[1] : lo_q[1];
					default: iss_val = ci_q[0] ? hi_q[2] : lo_q[2];
				endcase
			end
			ST_SAMPLE: begin
				iss_tag.valid = 1'b1;
				iss_tag.first = (ax_q == AX_X);
				iss_tag.last  = (ax_q == AX_Z);
				iss_tag.kind  = KIND_SAMPLE;
				case (ax_q)
					AX_X: iss_val = cur_q[0];
					AX_Y: iss_val = cur_q[1];
					default: iss_val = cur_q[2];
				endcase
			end
			ST_FINISH: fin = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_q  <= '0;
			ax_q  <= AX_X;
			a_q   <= '0;
			b_q   <= '0;
			c_q   <= '0;
			cls_q <= CLASS_INSIDE;
		end else begin
			case (state_q)
				ST_INIT: begin
					ci_q <= '0;
					ax_q <= AX_X;
					a_q  <= '0;
					b_q  <= '0;
					c_q  <= '0;
				end
				ST_CORNER: begin
					ax_q <= (ax_q == AX_Z) ? AX_X : ax_q + 2'd1;
					if (ax_q == AX_Z) begin
						ci_q <= ci_q + 3'd1;
					end
				end
				ST_CDRAIN: begin
					if (!stat.busy) begin
						cls_q <= stat.all_in ? CLASS_INSIDE : CLASS_OUTSIDE;
					end
				end
				ST_SAMPLE: begin
					ax_q <= (ax_q == AX_Z) ? AX_X : ax_q + 2'd1;
					if (ax_q == AX_Z) begin
						if (c_q == LAST) begin
							c_q <= '0;
							if (b_q == LAST) begin
								b_q <= '0;
								a_q <= a_q + CW'(1);
							end else begin
								b_q <= b_q + CW'(1);
							end
						end else begin
							c_q <= c_q + CW'(1);
						end
					end
				end
				ST_SDRAIN: cls_q <= CLASS_SAMPLED;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cell_q <= cell_in;
				end
			end
			ST_SETUP: begin
				for (int i = 0; i < 3; i++) begin
					lo_q[i] <= VAL_W'(diff[i]) * VAL_W'(K);
					ks_q[i] <= VAL_W'(size_in[i]) * VAL_W'(K);
				end
			end
			ST_INIT: begin
				for (int i = 0; i < 3; i++) begin
					hi_q[i]  <= lo_q[i] + ks_q[i];
					st_q[i]  <= lo_q[i] + VAL_W'(size_in[i]);
					cur_q[i] <= lo_q[i] + VAL_W'(size_in[i]);
				end
			end
			ST_SAMPLE: begin
				if (ax_q == AX_Z) begin
					if (c_q == LAST) begin
						cur_q[2] <= st_q[2];
						if (b_q == LAST) begin
							cur_q[1] <= st_q[1];
							cur_q[0] <= cur_q[0] + VAL_W'({size_in[0], 1'b0});
						end else begin
							cur_q[1] <= cur_q[1] + VAL_W'({size_in[1], 1'b0});
						end
					end else begin
						cur_q[2] <= cur_q[2] + VAL_W'({size_in[2], 1'b0});
					end
				end
			end
			default: ;
		endcase
	end

	assign cls = cls_q;

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
	import scvf_pkg::*;

	localparam int SUBDIV = SUBDIV_DEF;
	localparam longint SCALE = 2 * SUBDIV;
	localparam int FULL_RAW = SUBDIV * SUBDIV * SUBDIV;
	localparam int FULL_COUNT = (FULL_RAW > 1023) ? 1023 : FULL_RAW;
	localparam longint U = 65536;
	localparam longint C_MAX = (64'sd1 <<< 31) - 1;
	localparam longint C_MIN = -(64'sd1 <<< 31);
	localparam longint SIZE_MAX = C_MAX;
	localparam int HOLD_CYCLES = 3000;
	localparam int LIMIT = 6000000;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [CLASS_W-1:0] cls;
	} frac_t;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [287:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [15:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         cfg_we = 1'b0;
	logic [30:0]  cfg_wdata = '0;
	logic         hold_req = 1'b0;

	cell_t       cell_queue[$];
	frac_t       frac_expected[$];
	cell_t       cur_cell;
	frac_t       want;
	logic [30:0] sphere_r = 31'd65536;
	int          hold_cnt;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          n_queued = 0;
	int          n_accepted = 0;
	int          n_results = 0;
	int          n_errors = 0;
	int          n_radii = 1;
	int          n_in = 0;
	int          n_out = 0;
	int          n_samp = 0;
	int          cycles = 0;

	sphere_cell_volume_fraction #(
		.SUBDIV(SUBDIV)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	function automatic logic [127:0] dist2(input longint dx, input longint dy,
			input longint dz);
		logic [127:0] ax, ay, az;
		ax = 128'((dx < 0) ? -dx : dx);
		ay = 128'((dy < 0) ? -dy : dy);
		az = 128'((dz < 0) ? -dz : dz);
		return ax * ax + ay * ay + az * az;
	endfunction

	function automatic frac_t volume_fraction(input cell_t c, input logic [30:0] rad);
		longint bx, by, bz, sx, sy, sz;
		logic [127:0] rs, r2, d;
		logic all_in, all_out;
		int cnt;
		frac_t f;
		bx = SCALE * (longint'(c.x_low) - longint'(c.cx));
		by = SCALE * (longint'(c.y_low) - longint'(c.cy));
		bz = SCALE * (longint'(c.z_low) - longint'(c.cz));
		sx = longint'(c.sx);
		sy = longint'(c.sy);
		sz = longint'(c.sz);
		rs = 128'(longint'(rad) * SCALE);
		r2 = rs * rs;
		all_in = 1'b1;
		all_out = 1'b1;
		cnt = 0;
		for (int i = 0; i < 2; i++)
			for (int j = 0; j < 2; j++)
				for (int k = 0; k < 2; k++) begin
					d = dist2(bx + i * SCALE * sx, by + j * SCALE * sy, bz + k * SCALE * sz);
					if (d >= r2)
						all_in = 1'b0;
					if (d <= r2)
						all_out = 1'b0;
				end
		if (all_in) begin
			f.count = '0;
			f.cls = CLASS_INSIDE;
		end else if (all_out) begin
			f.count = COUNT_W'(FULL_COUNT);
			f.cls = CLASS_OUTSIDE;
		end else begin
			for (int i = 0; i < SUBDIV; i++)
				for (int j = 0; j < SUBDIV; j++)
					for (int k = 0; k < SUBDIV; k++) begin
						d = dist2(bx + (2 * i + 1) * sx, by + (2 * j + 1) * sy,
							bz + (2 * k + 1) * sz);
						if (d > r2)
							cnt++;
					end
			f.count = COUNT_W'((cnt > 1023) ? 1023 : cnt);
			f.cls = CLASS_SAMPLED;
		end
		return f;
	endfunction

	function automatic cell_t mk_cell(input longint x, input longint y, input longint z,
			input longint sx, input longint sy, input longint sz,
			input longint cx, input longint cy, input longint cz);
		cell_t c;
		c.x_low = x[31:0];
		c.y_low = y[31:0];
		c.z_low = z[31:0];
		c.sx = sx[30:0];
		c.sy = sy[30:0];
		c.sz = sz[30:0];
		c.cx = cx[31:0];
		c.cy = cy[31:0];
		c.cz = cz[31:0];
		return c;
	endfunction

	function automatic longint rnd_to(input longint n);
		logic [63:0] v;
		v = {$urandom, $urandom};
		return longint'(v % 64'(n + 1));
	endfunction

	// crossing, touching, inside, outside or full-range cells around a random centre
	function automatic cell_t rand_cell(input logic [30:0] rad, input bit quick);
		longint rr, rl;
		longint c[3];
		longint lo[3];
		longint s[3];
		int sel;
		rl = longint'(rad);
		rr = (rl < 64) ? 64 : rl;
		sel = quick ? $urandom_range(84, 50) : $urandom_range(99, 0);
		for (int i = 0; i < 3; i++) begin
			c[i] = longint'($signed($urandom)) >>> $urandom_range(16, 0);
			if (sel < 45) begin
				s[i] = rnd_to((2 * rr > SIZE_MAX) ? SIZE_MAX : 2 * rr);
				lo[i] = c[i] - rr - s[i] + rnd_to(2 * rr + s[i]);
			end else if (sel < 50) begin
				s[i] = rnd_to(rr);
				lo[i] = c[i];
			end else if (sel < 70) begin
				s[i] = rnd_to(rr / 2);
				lo[i] = c[i] - s[i] / 2 + rnd_to(rr / 4) - rr / 8;
			end else if (sel < 85) begin
				s[i] = rnd_to(rr);
				if ($urandom_range(1, 0))
					lo[i] = c[i] + rr + 1 + rnd_to(2 * rr);
				else
					lo[i] = c[i] - rr - 1 - rnd_to(2 * rr) - s[i];
			end else begin
				c[i] = longint'($signed($urandom));
				s[i] = longint'($urandom >> 1);
				lo[i] = longint'($signed($urandom));
			end
		end
		// one corner exactly on the sphere
		if (sel >= 45 && sel < 50)
			lo[0] = $urandom_range(1, 0) ? c[0] + rl : c[0] - rl - s[0];
		return mk_cell(lo[0], lo[1], lo[2], s[0], s[1], s[2], c[0], c[1], c[2]);
	endfunction

	task automatic push_cell(input cell_t c);
		cell_queue.push_back(c);
		n_queued++;
	endtask

	task automatic push_random(input int n, input bit quick);
		for (int i = 0; i < n; i++)
			push_cell(rand_cell(sphere_r, quick));
	endtask

	task automatic drain();
		while (n_accepted != n_queued || frac_expected.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_radius(input logic [30:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		sphere_r = v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		n_radii++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				want = volume_fraction(cur_cell, sphere_r);
				frac_expected.push_back(want);
				n_accepted++;
				case (want.cls)
					CLASS_INSIDE: n_in++;
					CLASS_OUTSIDE: n_out++;
					default: n_samp++;
				endcase
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (cell_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					cur_cell = cell_queue.pop_front();
					s_axis_tdata <= {3'b000, cur_cell};
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_cnt <= 0;
		else if (hold_req)
			hold_cnt <= HOLD_CYCLES;
		else if (hold_cnt != 0)
			hold_cnt <= hold_cnt - 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= (hold_cnt == 0) && ($urandom_range(99, 0) >= recv_stall_pct);
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (frac_expected.size() == 0) begin
				$display("%0t: result with no transaction pending: tdata %h tuser %h",
					$time, m_axis_tdata, m_axis_tuser);
				n_errors++;
			end else begin
				want = frac_expected.pop_front();
				if (m_axis_tdata !== {{(16 - COUNT_W){1'b0}}, want.count}) begin
					$display("%0t: outside_count mismatch: expected %0d actual %0d",
						$time, want.count, m_axis_tdata);
					n_errors++;
				end
				if (m_axis_tuser !== want.cls) begin
					$display("%0t: cell_class mismatch: expected %0d actual %0d",
						$time, want.cls, m_axis_tuser);
					n_errors++;
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// radius 1.0 from reset
		push_cell(mk_cell(-U / 4, -U / 4, -U / 4, U / 2, U / 2, U / 2, 0, 0, 0));
		push_cell(mk_cell(2 * U, 2 * U, 2 * U, U, U, U, 0, 0, 0));
		push_cell(mk_cell(0, 0, 0, U, U, U, 0, 0, 0));
		push_cell(mk_cell(U, 0, 0, U, U, U, 0, 0, 0));
		push_cell(mk_cell(0, 0, 0, U, 0, 0, 0, 0, 0));
		push_cell(mk_cell(-U, 0, 0, U, 0, 0, 0, 0, 0));
		push_cell(mk_cell(U / 2, 0, 0, 0, 0, 0, 0, 0, 0));
		push_cell(mk_cell(3 * U, 0, 0, 0, 0, 0, 0, 0, 0));
		push_cell(mk_cell(0, U, 0, 0, 0, 0, 0, 0, 0));
		push_cell(mk_cell(-U / 2, -U / 2, 0, U, U, 0, 0, 0, 0));
		push_cell(mk_cell(-U, -U, 0, 2 * U, 2 * U, 0, 0, 0, 0));
		push_cell(mk_cell(327680, -245760, 425984, U, U, U, 360448, -212992, 458752));
		push_cell(mk_cell(294912, -278528, 393216, 2 * U, 2 * U, 2 * U,
			360448, -212992, 458752));
		push_cell(mk_cell(C_MIN, C_MIN, C_MIN, SIZE_MAX, SIZE_MAX, SIZE_MAX,
			C_MAX, C_MAX, C_MAX));
		push_cell(mk_cell(C_MAX, C_MAX, C_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX,
			C_MIN, C_MIN, C_MIN));
		push_cell(mk_cell(C_MIN, C_MIN, C_MIN, SIZE_MAX, SIZE_MAX, SIZE_MAX, 0, 0, 0));
		push_cell(mk_cell(C_MAX, C_MAX, C_MAX, 0, 0, 0, C_MAX, C_MAX, C_MAX));
		push_cell(mk_cell(-1, -1, -1, 2, 2, 2, 0, 0, 0));
		push_cell(mk_cell(C_MIN, 0, 0, 0, 0, 0, C_MAX, 0, 0));
		push_cell(mk_cell(0, 0, 0, SIZE_MAX, SIZE_MAX, SIZE_MAX, 0, 0, 0));
		drain();

		set_radius(31'd196608);
		push_random(120, 1'b0);
		drain();

		set_radius(31'd0);
		send_idle_pct = 53;
		push_cell(mk_cell(0, 0, 0, 0, 0, 0, 0, 0, 0));
		push_cell(mk_cell(0, 0, 0, U, U, U, 0, 0, 0));
		push_cell(mk_cell(U, 0, 0, U, U, U, 0, 0, 0));
		push_random(100, 1'b0);
		drain();

		set_radius(31'h7fffffff);
		send_idle_pct = 0;
		recv_stall_pct = 53;
		push_cell(mk_cell(0, 0, 0, U, U, U, 0, 0, 0));
		push_cell(mk_cell(C_MAX, 0, 0, 0, 0, 0, 0, 0, 0));
		push_random(100, 1'b0);
		drain();

		set_radius(31'($urandom_range(32'h7fffffff, 1)));
		send_idle_pct = 28;
		recv_stall_pct = 28;
		push_random(120, 1'b0);
		drain();

		set_radius(31'd1);
		send_idle_pct = 53;
		recv_stall_pct = 0;
		push_random(80, 1'b0);
		drain();

		// receiver held off while quick cells keep coming
		set_radius(31'd131072);
		send_idle_pct = 0;
		@(posedge clk);
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		@(negedge clk);
		push_random(30, 1'b1);
		drain();

		send_idle_pct = 28;
		recv_stall_pct = 28;
		push_random(150, 1'b0);
		drain();

		repeat (50) @(posedge clk);
		$display("%0d cells over %0d radius settings: %0d inside, %0d outside, %0d sampled",
			n_accepted, n_radii, n_in, n_out, n_samp);
		$display("%0d results checked, %0d mismatches", n_results, n_errors);
		if (n_errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
